[src/cssr_pkg.sv]
package cssr_pkg;

   localparam int DEF_BUFFER_DEPTH = 128;
   localparam int DEF_SAMPLE_WIDTH = 16;

   localparam int CSR_ADDR_WIDTH = 6;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int REG_WIDTH      = 48;
   localparam int FIELD_WIDTH    = 16;
   localparam int INDEX_WIDTH    = 7;

   localparam logic [REG_WIDTH-1:0]   OFFSET_RESET = 48'h0;
   localparam logic [REG_WIDTH-1:0]   ROW_X_RESET  = 48'h0000_0000_1000;
   localparam logic [REG_WIDTH-1:0]   ROW_Y_RESET  = 48'h0000_1000_0000;
   localparam logic [REG_WIDTH-1:0]   ROW_Z_RESET  = 48'h1000_0000_0000;
   localparam logic [FIELD_WIDTH-1:0] FIELD_RESET  = 16'd50;

   // gap_error is Q8.8: 25.0, 1.0 and 10.0
   localparam logic [15:0] GAP_PURGE_MAX = 16'd6400;
   localparam logic [15:0] GAP_FLOOR     = 16'd256;
   localparam logic [19:0] LIMIT_SCALE   = 20'd10;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      CFG_OFFSET,
      CFG_ROW_X,
      CFG_ROW_Y,
      CFG_ROW_Z,
      CFG_FIELD
   } cfg_index_type;

   typedef enum logic [1:0] {
      KIND_FREE,
      KIND_WORST,
      KIND_PAIR,
      KIND_CLEAR
   } kind_type;

   // width of raw minus offset
   function automatic int cssr_dw(input int sw);
      return ((sw > 16) ? sw : 16) + 1;
   endfunction

   // width of a calibrated axis, also of the magnitude and its error
   function automatic int cssr_cw(input int sw);
      return cssr_dw(sw) + 6;
   endfunction

endpackage

[src/cssr_cal.sv]
module cssr_cal #(
   parameter int SAMPLE_WIDTH = cssr_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   input  logic [3*SAMPLE_WIDTH-1:0]                  sample,
   input  logic [cssr_pkg::REG_WIDTH-1:0]             offset_xyz,
   input  logic [cssr_pkg::REG_WIDTH-1:0]             matrix_row_x,
   input  logic [cssr_pkg::REG_WIDTH-1:0]             matrix_row_y,
   input  logic [cssr_pkg::REG_WIDTH-1:0]             matrix_row_z,
   input  logic [cssr_pkg::FIELD_WIDTH-1:0]           field_strength,
   output logic                                       done,
   output logic [cssr_pkg::cssr_cw(SAMPLE_WIDTH)-1:0] err
);
   import cssr_pkg::*;

   localparam int SW   = SAMPLE_WIDTH;
   localparam int DW   = cssr_dw(SW);
   localparam int SUMW = DW + 18;
   localparam int RW   = cssr_cw(SW);
   localparam int SQW  = 2 * RW;
   localparam int NW   = $clog2(RW + 1);

   typedef enum logic [2:0] {C_IDLE, C_MAC, C_SQ, C_ROOT, C_DONE} state_type;

   state_type               state_ff;
   logic signed [DW-1:0]    d_ff [3];
   logic signed [SUMW-1:0]  acc_ff;
   logic signed [RW-1:0]    c_ff [3];
   logic [1:0]              k_ff;
   logic [1:0]              r_ff;
   logic [SQW-1:0]          sq_ff;
   logic [SQW-1:0]          val_ff;
   logic [RW+1:0]           rem_ff;
   logic [RW-1:0]           root_ff;
   logic [NW-1:0]           cnt_ff;
   logic                    done_ff;
   logic [RW-1:0]           err_ff;

   logic [REG_WIDTH-1:0]    row_sel;
   logic signed [15:0]      coef;
   logic signed [DW+15:0]   prod;
   logic signed [SUMW-1:0]  sum_in;
   logic signed [SUMW-1:0]  round_in;
   logic signed [2*RW-1:0]  csq;
   logic [SQW-1:0]          sq_in;
   logic [RW+3:0]           rem_sh;
   logic [RW+3:0]           trial;
   logic [RW-1:0]           fs_ext;

   always_comb begin
      case (r_ff)
         2'd0:    row_sel = matrix_row_x;
         2'd1:    row_sel = matrix_row_y;
         default: row_sel = matrix_row_z;
      endcase
      coef     = $signed(row_sel[16*k_ff +: 16]);
      prod     = coef * d_ff[k_ff];
      sum_in   = acc_ff + SUMW'(prod);
      round_in = sum_in + SUMW'(2048);
      csq      = c_ff[r_ff] * c_ff[r_ff];
      sq_in    = sq_ff + SQW'($unsigned(csq));
      rem_sh   = {rem_ff, val_ff[SQW-1 -: 2]};
      trial    = {2'b00, root_ff, 2'b01};
      fs_ext   = RW'(field_strength);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            C_IDLE: begin
               if (start) begin
                  for (int k = 0; k < 3; k++) begin
                     d_ff[k] <= DW'($signed(sample[k*SW +: SW]))
                              - DW'($signed(offset_xyz[16*k +: 16]));
                  end
                  acc_ff   <= '0;
                  sq_ff    <= '0;
                  k_ff     <= 2'd0;
                  r_ff     <= 2'd0;
                  state_ff <= C_MAC;
               end
            end
            C_MAC: begin
               if (k_ff == 2'd2) begin
                  c_ff[r_ff] <= RW'(round_in >>> 12);
                  acc_ff     <= '0;
                  k_ff       <= 2'd0;
                  if (r_ff == 2'd2) begin
                     r_ff     <= 2'd0;
                     state_ff <= C_SQ;
                  end else begin
                     r_ff <= r_ff + 2'd1;
                  end
               end else begin
                  acc_ff <= sum_in;
                  k_ff   <= k_ff + 2'd1;
               end
            end
            C_SQ: begin
               sq_ff <= sq_in;
               if (r_ff == 2'd2) begin
                  val_ff   <= sq_in;
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= NW'(RW);
                  state_ff <= C_ROOT;
               end else begin
                  r_ff <= r_ff + 2'd1;
               end
            end
            C_ROOT: begin
               if (rem_sh >= trial) begin
                  rem_ff  <= (RW+2)'(rem_sh - trial);
                  root_ff <= {root_ff[RW-2:0], 1'b1};
               end else begin
                  rem_ff  <= (RW+2)'(rem_sh);
                  root_ff <= {root_ff[RW-2:0], 1'b0};
               end
               val_ff <= {val_ff[SQW-3:0], 2'b00};
               cnt_ff <= cnt_ff - NW'(1);
               if (cnt_ff == NW'(1)) begin
                  state_ff <= C_DONE;
               end
            end
            C_DONE: begin
               err_ff   <= (root_ff >= fs_ext) ? root_ff - fs_ext : fs_ext - root_ff;
               done_ff  <= 1'b1;
               state_ff <= C_IDLE;
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign err  = err_ff;

endmodule

[src/calibration_sample_slot_replacement.sv]
// Channel   Ports                 Direction  Transfer
// request   req_*                 in         req_valid & req_ready
// response  rsp_*                 out        rsp_valid & rsp_ready
// csr       csr_* (APB, 64-bit)   in/out     psel & penable & pwrite
//
// One item at a time.
// With a full buffer the closest-pair scan runs over the single memory read port;
// a purge runs each slot in turn through the calibrate/sqrt unit.
// Synchronous reset empties the buffer at once (fill count); no clearing pass.
// A waiting response does not block the next request transfer.
module calibration_sample_slot_replacement #(
   parameter int BUFFER_DEPTH = cssr_pkg::DEF_BUFFER_DEPTH,
   parameter int SAMPLE_WIDTH = cssr_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic signed [15:0]                  req_sample_x,
   input  logic signed [15:0]                  req_sample_y,
   input  logic signed [15:0]                  req_sample_z,
   input  logic [15:0]                         req_gap_error,
   input  logic                                req_random_bit,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cssr_pkg::INDEX_WIDTH-1:0]    rsp_slot_index,
   output logic                                rsp_slot_was_used,
   output logic [1:0]                          rsp_choice_kind,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cssr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [cssr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [cssr_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import cssr_pkg::*;

   localparam int SW  = SAMPLE_WIDTH;
   localparam int MW  = 3 * SW;
   localparam int IW  = $clog2(BUFFER_DEPTH);
   localparam int CW  = $clog2(BUFFER_DEPTH + 1);
   localparam int DSW = 2 * SW + 4;
   localparam int EW  = cssr_cw(SW);

   typedef enum logic [3:0] {
      S_IDLE, S_PURGE_RD, S_PURGE_LOAD, S_PURGE_CAL,
      S_PAIR_RI, S_PAIR_LI, S_PAIR_J, S_PAIR_DRAIN, S_FINISH
   } state_type;

   logic [REG_WIDTH-1:0]   offset_ff;
   logic [REG_WIDTH-1:0]   row_x_ff;
   logic [REG_WIDTH-1:0]   row_y_ff;
   logic [REG_WIDTH-1:0]   row_z_ff;
   logic [FIELD_WIDTH-1:0] field_ff;
   cfg_index_type          cfg_idx;

   assign cfg_idx    = cfg_index_type'(csr_paddr[5:3]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
         row_x_ff  <= ROW_X_RESET;
         row_y_ff  <= ROW_Y_RESET;
         row_z_ff  <= ROW_Z_RESET;
         field_ff  <= FIELD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (cfg_idx)
            CFG_OFFSET: offset_ff <= csr_pwdata[REG_WIDTH-1:0];
            CFG_ROW_X:  row_x_ff  <= csr_pwdata[REG_WIDTH-1:0];
            CFG_ROW_Y:  row_y_ff  <= csr_pwdata[REG_WIDTH-1:0];
            CFG_ROW_Z:  row_z_ff  <= csr_pwdata[REG_WIDTH-1:0];
            CFG_FIELD:  field_ff  <= csr_pwdata[FIELD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         CFG_OFFSET: csr_prdata = CSR_DATA_WIDTH'(offset_ff);
         CFG_ROW_X:  csr_prdata = CSR_DATA_WIDTH'(row_x_ff);
         CFG_ROW_Y:  csr_prdata = CSR_DATA_WIDTH'(row_y_ff);
         CFG_ROW_Z:  csr_prdata = CSR_DATA_WIDTH'(row_z_ff);
         CFG_FIELD:  csr_prdata = CSR_DATA_WIDTH'(field_ff);
         default:    csr_prdata = '0;
      endcase
   end

   state_type        state_ff;
   logic [CW-1:0]    count_ff;
   logic [7:0]       purge_ff;
   logic             op_ff;
   logic [MW-1:0]    sam_ff;
   logic             rnd_ff;
   logic [IW-1:0]    slot_ff;
   logic             used_ff;
   kind_type         kind_ff;
   logic [IW-1:0]    s_ff;
   logic [EW-1:0]    emax_ff;
   logic             pfound_ff;
   logic [IW-1:0]    i_ff;
   logic [IW-1:0]    j_ff;
   logic [MW-1:0]    row_i_ff;
   logic [DSW-1:0]   best_ff;
   logic [IW-1:0]    bi_ff;
   logic [IW-1:0]    bj_ff;
   logic             p1_valid_ff;
   logic [IW-1:0]    p1_j_ff;
   logic             p2_valid_ff;
   logic [IW-1:0]    p2_j_ff;
   logic [2*SW+1:0]  sq_ff [3];
   logic             rsp_valid_ff;
   logic [IW-1:0]    rsp_slot_ff;
   logic             rsp_used_ff;
   kind_type         rsp_kind_ff;

   logic [MW-1:0]    mem [BUFFER_DEPTH];
   logic [MW-1:0]    rd_data_ff;
   logic [IW-1:0]    raddr;
   logic             wr_en;

   logic             full;
   logic [15:0]      gap_floor;
   logic [15:0]      limit;
   logic [7:0]       purge_inc;
   logic             purge_go;
   logic             rsp_free;
   logic             cal_start;
   logic             cal_done;
   logic [EW-1:0]    cal_err;
   logic             better;
   logic [DSW-1:0]   dsum;
   logic [IW+6:0]    slot_ext;
   logic signed [SW:0]     pdiff [3];
   logic signed [2*SW+1:0] psq   [3];

   assign full      = (count_ff == CW'(BUFFER_DEPTH));
   assign gap_floor = (req_gap_error < GAP_FLOOR) ? GAP_FLOOR : req_gap_error;
   assign limit     = 16'((20'(gap_floor) * LIMIT_SCALE) >> 8);
   assign purge_inc = purge_ff + 8'd1;
   assign purge_go  = (16'(purge_inc) > limit);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign cal_start = (state_ff == S_PURGE_LOAD);
   assign better    = (cal_err > emax_ff);
   assign dsum      = DSW'(sq_ff[0]) + DSW'(sq_ff[1]) + DSW'(sq_ff[2]);
   assign wr_en     = (state_ff == S_FINISH) && rsp_free && (op_ff == OP_ADD);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      case (state_ff)
         S_PURGE_RD: raddr = s_ff;
         S_PAIR_RI:  raddr = i_ff;
         default:    raddr = j_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[slot_ff] <= sam_ff;
      end
      rd_data_ff <= mem[raddr];
   end

   cssr_cal #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_cal (
      .clock          (clock),
      .reset          (reset),
      .start          (cal_start),
      .sample         (rd_data_ff),
      .offset_xyz     (offset_ff),
      .matrix_row_x   (row_x_ff),
      .matrix_row_y   (row_y_ff),
      .matrix_row_z   (row_z_ff),
      .field_strength (field_ff),
      .done           (cal_done),
      .err            (cal_err)
   );

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pdiff[k] = (SW+1)'($signed(row_i_ff[k*SW +: SW]))
                  - (SW+1)'($signed(rd_data_ff[k*SW +: SW]));
         psq[k]   = pdiff[k] * pdiff[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         sq_ff[k] <= $unsigned(psq[k]);
      end
      p1_j_ff <= j_ff;
      p2_j_ff <= p1_j_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         purge_ff     <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= (state_ff == S_PAIR_J);
         p2_valid_ff <= p1_valid_ff;
         if (p2_valid_ff && (dsum < best_ff)) begin
            best_ff <= dsum;
            bi_ff   <= i_ff;
            bj_ff   <= p2_j_ff;
         end
         if ((state_ff == S_FINISH) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff  <= req_op;
                  sam_ff <= {SW'(req_sample_z[15:0]), SW'(req_sample_y[15:0]),
                             SW'(req_sample_x[15:0])};
                  rnd_ff <= req_random_bit;
                  if (req_op == OP_CLEAR) begin
                     slot_ff  <= '0;
                     used_ff  <= 1'b0;
                     kind_ff  <= KIND_CLEAR;
                     state_ff <= S_FINISH;
                  end else if (!full) begin
                     slot_ff  <= count_ff[IW-1:0];
                     used_ff  <= 1'b0;
                     kind_ff  <= KIND_FREE;
                     state_ff <= S_FINISH;
                  end else begin
                     used_ff <= 1'b1;
                     i_ff    <= '0;
                     best_ff <= '1;
                     if (req_gap_error >= GAP_PURGE_MAX) begin
                        purge_ff <= '0;
                        state_ff <= S_PAIR_RI;
                     end else if (purge_go) begin
                        purge_ff  <= '0;
                        s_ff      <= '0;
                        emax_ff   <= '0;
                        pfound_ff <= 1'b0;
                        state_ff  <= S_PURGE_RD;
                     end else begin
                        purge_ff <= purge_inc;
                        state_ff <= S_PAIR_RI;
                     end
                  end
               end
            end
            S_PURGE_RD:   state_ff <= S_PURGE_LOAD;
            S_PURGE_LOAD: state_ff <= S_PURGE_CAL;
            S_PURGE_CAL: begin
               if (cal_done) begin
                  if (better) begin
                     emax_ff   <= cal_err;
                     slot_ff   <= s_ff;
                     pfound_ff <= 1'b1;
                  end
                  if (s_ff == IW'(BUFFER_DEPTH - 1)) begin
                     if (pfound_ff || better) begin
                        kind_ff  <= KIND_WORST;
                        state_ff <= S_FINISH;
                     end else begin
                        state_ff <= S_PAIR_RI;
                     end
                  end else begin
                     s_ff     <= s_ff + IW'(1);
                     state_ff <= S_PURGE_RD;
                  end
               end
            end
            S_PAIR_RI: state_ff <= S_PAIR_LI;
            S_PAIR_LI: begin
               row_i_ff <= rd_data_ff;
               j_ff     <= i_ff + IW'(1);
               state_ff <= S_PAIR_J;
            end
            S_PAIR_J: begin
               if (j_ff == IW'(BUFFER_DEPTH - 1)) begin
                  state_ff <= S_PAIR_DRAIN;
               end else begin
                  j_ff <= j_ff + IW'(1);
               end
            end
            S_PAIR_DRAIN: begin
               if (!p1_valid_ff && !p2_valid_ff) begin
                  if (i_ff == IW'(BUFFER_DEPTH - 2)) begin
                     slot_ff  <= rnd_ff ? bi_ff : bj_ff;
                     kind_ff  <= KIND_PAIR;
                     state_ff <= S_FINISH;
                  end else begin
                     i_ff     <= i_ff + IW'(1);
                     state_ff <= S_PAIR_RI;
                  end
               end
            end
            S_FINISH: begin
               if (rsp_free) begin
                  if (op_ff == OP_CLEAR) begin
                     count_ff <= '0;
                  end else if (kind_ff == KIND_FREE) begin
                     count_ff <= count_ff + CW'(1);
                  end
                  rsp_slot_ff  <= slot_ff;
                  rsp_used_ff  <= used_ff;
                  rsp_kind_ff  <= kind_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign slot_ext          = {7'b0, rsp_slot_ff};
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot_index    = slot_ext[INDEX_WIDTH-1:0];
   assign rsp_slot_was_used = rsp_used_ff;
   assign rsp_choice_kind   = rsp_kind_ff;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import cssr_pkg::*;

   localparam int DEPTH      = 128;
   localparam int STALL_LIMIT = 200000;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] slot;
      logic                   used;
      kind_type               kind;
   } placement_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_op;
   logic signed [15:0] req_sample_x;
   logic signed [15:0] req_sample_y;
   logic signed [15:0] req_sample_z;
   logic [15:0] req_gap_error;
   logic req_random_bit;
   logic rsp_valid;
   logic rsp_ready;
   logic [INDEX_WIDTH-1:0] rsp_slot_index;
   logic rsp_slot_was_used;
   logic [1:0] rsp_choice_kind;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   calibration_sample_slot_replacement dut (.*);

   // model state
   logic [47:0] cal_offset;
   logic [47:0] cal_row [3];
   logic [15:0] cal_field;
   int          held_sample [DEPTH][3];
   bit          held_valid [DEPTH];
   logic [7:0]  purge_count;

   placement_type pending_placements[$];
   int  error_count;
   int  full_adds;
   bit  gaps_on;
   int  idle_cycles;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint lane(input logic [47:0] r, input int k);
      return longint'($signed(r[16*k +: 16]));
   endfunction

   function automatic longint unsigned field_miss(input int s);
      longint d[3];
      longint c;
      longint unsigned sq;
      longint unsigned mag;
      sq = 0;
      for (int k = 0; k < 3; k++) d[k] = longint'(held_sample[s][k]) - lane(cal_offset, k);
      for (int a = 0; a < 3; a++) begin
         c = lane(cal_row[a], 0) * d[0] + lane(cal_row[a], 1) * d[1]
             + lane(cal_row[a], 2) * d[2] + 2048;
         c = c >>> 12;
         if (c < 0) c = -c;
         sq += longint'(c) * longint'(c);
      end
      mag = int_sqrt(sq);
      return (mag >= cal_field) ? mag - cal_field : cal_field - mag;
   endfunction

   function automatic placement_type place_sample(input logic op, input int x, input int y,
                                                  input int z, input logic [15:0] gap,
                                                  input logic coin);
      placement_type p;
      bit found;
      int slot;
      longint unsigned lim;
      longint unsigned worst;
      longint unsigned e;
      longint unsigned best;
      longint unsigned dsq;
      longint dd;
      int bi;
      int bj;
      p = '0;
      if (op == OP_CLEAR) begin
         foreach (held_valid[i]) held_valid[i] = 0;
         p.kind = KIND_CLEAR;
         return p;
      end
      found = 0;
      slot = 0;
      p.kind = KIND_FREE;
      for (int i = 0; i < DEPTH; i++)
         if (!found && !held_valid[i]) begin
            slot = i;
            found = 1;
         end
      if (!found) begin
         p.used = 1;
         if (gap < GAP_PURGE_MAX) begin
            lim = ((gap < GAP_FLOOR) ? 256 : gap) * 10 / 256;
            purge_count = 8'(purge_count + 8'd1);
            if (purge_count > lim) begin
               worst = 0;
               for (int i = 0; i < DEPTH; i++) begin
                  e = field_miss(i);
                  if (e > worst) begin
                     worst = e;
                     slot = i;
                     found = 1;
                  end
               end
               purge_count = 0;
               if (found) p.kind = KIND_WORST;
            end
         end else begin
            purge_count = 0;
         end
         if (!found) begin
            best = '1;
            bi = 0;
            bj = 1;
            for (int i = 0; i < DEPTH; i++)
               for (int j = i + 1; j < DEPTH; j++) begin
                  dsq = 0;
                  for (int k = 0; k < 3; k++) begin
                     dd = longint'(held_sample[i][k]) - longint'(held_sample[j][k]);
                     dsq += dd * dd;
                  end
                  if (dsq < best) begin
                     best = dsq;
                     bi = i;
                     bj = j;
                  end
               end
            slot = coin ? bi : bj;
            p.kind = KIND_PAIR;
         end
      end
      held_sample[slot][0] = x;
      held_sample[slot][1] = y;
      held_sample[slot][2] = z;
      held_valid[slot] = 1;
      p.slot = slot[INDEX_WIDTH-1:0];
      return p;
   endfunction

   task automatic send_sample(input logic op, input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z, input logic [15:0] gap,
                              input logic coin);
      placement_type p;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_sample_x   <= x;
      req_sample_y   <= y;
      req_sample_z   <= z;
      req_gap_error  <= gap;
      req_random_bit <= coin;
      do @(posedge clock); while (!req_ready);
      p = place_sample(op, int'($signed(x)), int'($signed(y)), int'($signed(z)), gap, coin);
      if (p.kind != KIND_FREE && p.kind != KIND_CLEAR) full_adds++;
      pending_placements.push_back(p);
   endtask

   task automatic send_random_add(input logic [15:0] gap);
      send_sample(OP_ADD, 16'($urandom), 16'($urandom), 16'($urandom), gap,
                  1'($urandom_range(0, 1)));
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_reg(input cfg_index_type idx, input logic [63:0] value);
      drain();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'(8 * int'(idx));
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         CFG_OFFSET: cal_offset = value[47:0];
         CFG_ROW_X:  cal_row[0] = value[47:0];
         CFG_ROW_Y:  cal_row[1] = value[47:0];
         CFG_ROW_Z:  cal_row[2] = value[47:0];
         CFG_FIELD:  cal_field  = value[15:0];
         default: ;
      endcase
   endtask

   task automatic fill_buffer;
      for (int i = 0; i < DEPTH; i++)
         if (!held_valid[i]) send_random_add(16'($urandom));
   endtask

   task automatic test_extremes;
      send_sample(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_sample(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'hffff, 1'b1);
      send_sample(OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 1'b0);
      send_sample(OP_ADD, 16'h0000, 16'hffff, 16'h8000, 16'h18ff, 1'b1);
      send_sample(OP_ADD, 16'h5555, 16'haaaa, 16'h0001, 16'h1900, 1'b0);
      send_sample(OP_CLEAR, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1);
      fill_buffer();
   endtask

   task automatic test_closest_pair;
      send_sample(OP_ADD, 16'h7fff, 16'h8000, 16'h0000, 16'hffff, 1'b1);
      send_sample(OP_ADD, 16'h7fff, 16'h8000, 16'h0000, 16'h1900, 1'b0);
      send_sample(OP_ADD, 16'h7ffe, 16'h8000, 16'h0000, 16'h1900, 1'b1);
      send_sample(OP_ADD, 16'h1234, 16'h4321, 16'hfedc, 16'hffff, 1'b0);
   endtask

   task automatic test_purge_rate;
      // gap 0 floors to 1.0: limit 10, purge on the 11th full add
      for (int i = 0; i < 12; i++) send_random_add(16'h0000);
   endtask

   task automatic test_all_on_field;
      // zero matrix and zero field: every slot sits on the field, purge evicts nothing
      write_reg(CFG_ROW_X, 64'h0);
      write_reg(CFG_ROW_Y, 64'h0);
      write_reg(CFG_ROW_Z, 64'h0);
      write_reg(CFG_FIELD, 64'h0);
      for (int i = 0; i < 12; i++) send_random_add(16'h0000);
      write_reg(CFG_ROW_X, 64'h0000_0000_0000_1000);
      write_reg(CFG_ROW_Y, 64'h0000_0000_1000_0000);
      write_reg(CFG_ROW_Z, 64'h0000_1000_0000_0000);
      write_reg(CFG_FIELD, 64'd50);
   endtask

   task automatic test_config_extremes;
      write_reg(CFG_OFFSET, 64'h0000_8000_7fff_ffff);
      write_reg(CFG_ROW_X, 64'h0000_8000_7fff_1000);
      write_reg(CFG_ROW_Y, 64'h0000_7fff_8000_ffff);
      write_reg(CFG_ROW_Z, 64'h0000_ffff_0001_8000);
      write_reg(CFG_FIELD, 64'h0000_0000_0000_ffff);
      for (int i = 0; i < 11; i++) send_random_add(16'h0080);
      write_reg(CFG_FIELD, 64'h0);
      write_reg(CFG_OFFSET, 64'h0);
      write_reg(CFG_ROW_X, 64'h0000_0000_0000_1000);
      write_reg(CFG_ROW_Y, 64'h0000_0000_1000_0000);
      write_reg(CFG_ROW_Z, 64'h0000_1000_0000_0000);
   endtask

   task automatic test_random;
      logic [15:0] gap;
      while (full_adds < 48) begin
         case ($urandom_range(0, 3))
            0: gap = 16'($urandom);
            1: gap = 16'($urandom_range(6400, 65535));
            default: gap = 16'($urandom_range(0, 400));
         endcase
         send_random_add(gap);
         if (full_adds == 44) begin
            write_reg(CFG_FIELD, 64'($urandom_range(0, 65535)));
            write_reg(CFG_OFFSET, {16'h0, 16'($urandom_range(0, 255)),
                                   16'($urandom_range(0, 255)),
                                   16'($urandom_range(0, 255))});
            gaps_on = 0;
         end
      end
   endtask

   always @(negedge clock) begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         if (idle_cycles == 0) idle_cycles = $urandom_range(1, 3);
      end
      if (idle_cycles > 0) begin
         rsp_ready <= 1'b0;
         idle_cycles--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      placement_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_placements.size() == 0) begin
            $error("unexpected transfer: slot %0d", rsp_slot_index);
            error_count++;
         end else begin
            want = pending_placements.pop_front();
            if (rsp_slot_index !== want.slot) begin
               $error("slot_index: expected %0d, got %0d", want.slot, rsp_slot_index);
               error_count++;
            end
            if (rsp_slot_was_used !== want.used) begin
               $error("slot_was_used: expected %0d, got %0d", want.used, rsp_slot_was_used);
               error_count++;
            end
            if (rsp_choice_kind !== want.kind) begin
               $error("choice_kind: expected %0d, got %0d", want.kind, rsp_choice_kind);
               error_count++;
            end
         end
      end
   end

   int stall_count;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count = 0;
      end else begin
         stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_ADD;
      req_sample_x = '0;
      req_sample_y = '0;
      req_sample_z = '0;
      req_gap_error = '0;
      req_random_bit = 1'b0;
      rsp_ready = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      idle_cycles = 0;
      error_count = 0;
      full_adds = 0;
      gaps_on = 1;
      cal_offset = OFFSET_RESET;
      cal_row[0] = ROW_X_RESET;
      cal_row[1] = ROW_Y_RESET;
      cal_row[2] = ROW_Z_RESET;
      cal_field = FIELD_RESET;
      purge_count = 0;
      foreach (held_valid[i]) held_valid[i] = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_closest_pair();
      test_purge_rate();
      test_all_on_field();
      test_config_extremes();
      test_random();
      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

[files.f]
src/cssr_pkg.sv
src/cssr_cal.sv
src/calibration_sample_slot_replacement.sv
tb/testbench.sv
